### hdl/ray_radial_sector_hit_unit_defines.svh
// assertion helpers shared by the hit unit rtl
`ifndef RAY_RADIAL_SECTOR_HIT_UNIT_DEFINES_SVH
`define RAY_RADIAL_SECTOR_HIT_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsh check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define RSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsh check failed: next-cycle implication");

`endif

### hdl/rsh_pkg.sv
`timescale 1ns / 1ps
package rsh_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_W = 24;
    localparam int NUM_W   = 48;
    localparam int QUO_W   = 24;
    localparam int DEN_W   = 25;
    localparam int XY_W    = 25;
    localparam int CRD_W   = 27;
    localparam int ANG_W   = 16;
    localparam int RAD_W   = 18;

    // pipeline depths of the sub units
    localparam int DIV_LAT      = QUO_W + 1;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;

    localparam int MAX_BUTTONS_DEF = 9;

    // register indexes
    localparam logic [1:0] REG_CHILD_COUNT   = 2'd0;
    localparam logic [1:0] REG_MENU_VISIBLE  = 2'd1;
    localparam logic [1:0] REG_CENTER_RADIUS = 2'd2;
    localparam logic [1:0] REG_OUTER_RADIUS  = 2'd3;

    localparam logic [RAD_W-1:0] CENTER_RADIUS_RST = 18'd11141;
    localparam logic [RAD_W-1:0] OUTER_RADIUS_RST  = 18'd65536;

    // binary angles of the axes
    localparam logic [ANG_W-1:0] ANG_ZERO  = 16'd0;
    localparam logic [ANG_W-1:0] ANG_QUART = 16'd16384;
    localparam logic [ANG_W-1:0] ANG_HALF  = 16'd32768;
    localparam logic [ANG_W-1:0] ANG_3QUAR = 16'd49152;

    // atan(2^-i) in binary angle units
    localparam logic [ANG_W-1:0] ATAN_BAM [CORDIC_STEPS] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1, 16'd0
    };

    // per-item control that travels beside the data path
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
        logic in_outer;
        logic center;
    } t_side;

endpackage

### hdl/rsh_div.sv
`timescale 1ns / 1ps
module rsh_div import rsh_pkg::*; (
    input  logic               i_clk,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic [QUO_W-1:0]   o_quo
);

    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_low [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];

    // load: upper half is the starting remainder
    always_ff @(posedge i_clk) begin
        r_rem[0] <= {1'b0, i_num[NUM_W-1:QUO_W]};
        r_low[0] <= i_num[QUO_W-1:0];
        r_quo[0] <= '0;
        r_den[0] <= i_den;
    end

    // one restoring quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W:0] w_t;
        logic [DEN_W:0] w_d;
        logic           w_ge;
        assign w_t  = {r_rem[k], r_low[k][QUO_W-1]};
        assign w_ge = w_t >= {1'b0, r_den[k]};
        assign w_d  = w_t - {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= w_ge ? w_d[DEN_W-1:0] : w_t[DEN_W-1:0];
            r_low[k+1] <= {r_low[k][QUO_W-2:0], 1'b0};
            r_quo[k+1] <= {r_quo[k][QUO_W-2:0], w_ge};
            r_den[k+1] <= r_den[k];
        end
    end

    assign o_quo = r_quo[QUO_W];

endmodule

### hdl/rsh_cordic.sv
`timescale 1ns / 1ps
module rsh_cordic import rsh_pkg::*; (
    input  logic                    i_clk,
    input  logic signed [XY_W-1:0]  i_x,
    input  logic signed [XY_W-1:0]  i_y,
    output logic [ANG_W-1:0]        o_angle
);

    logic signed [CRD_W-1:0] r_x   [0:CORDIC_STEPS];
    logic signed [CRD_W-1:0] r_y   [0:CORDIC_STEPS];
    logic [ANG_W-1:0]        r_z   [0:CORDIC_STEPS];
    logic                    r_fix [0:CORDIC_STEPS];
    logic [ANG_W-1:0]        r_fa  [0:CORDIC_STEPS];

    logic signed [CRD_W-1:0] w_x;
    logic signed [CRD_W-1:0] w_y;
    logic                    w_neg;

    // fold the left half plane by 180 degrees
    assign w_x   = CRD_W'(i_x);
    assign w_y   = CRD_W'(i_y);
    assign w_neg = i_x < 0;

    // axis points take exact angles
    always_ff @(posedge i_clk) begin
        r_x[0]   <= w_neg ? -w_x : w_x;
        r_y[0]   <= w_neg ? -w_y : w_y;
        r_z[0]   <= w_neg ? ANG_HALF : ANG_ZERO;
        r_fix[0] <= (i_x == 0) || (i_y == 0);
        if (i_y == 0) begin
            r_fa[0] <= w_neg ? ANG_HALF : ANG_ZERO;
        end else begin
            r_fa[0] <= (i_y > 0) ? ANG_QUART : ANG_3QUAR;
        end
    end

    // vectoring steps, one per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [CRD_W-1:0] w_xs;
        logic signed [CRD_W-1:0] w_ys;
        assign w_xs = r_x[k] >>> k;
        assign w_ys = r_y[k] >>> k;
        always_ff @(posedge i_clk) begin
            if (r_y[k] >= 0) begin
                r_x[k+1] <= r_x[k] + w_ys;
                r_y[k+1] <= r_y[k] - w_xs;
                r_z[k+1] <= r_z[k] + ATAN_BAM[k];
            end else begin
                r_x[k+1] <= r_x[k] - w_ys;
                r_y[k+1] <= r_y[k] + w_xs;
                r_z[k+1] <= r_z[k] - ATAN_BAM[k];
            end
            r_fix[k+1] <= r_fix[k];
            r_fa[k+1]  <= r_fa[k];
        end
    end

    assign o_angle = r_fix[CORDIC_STEPS] ? r_fa[CORDIC_STEPS] : r_z[CORDIC_STEPS];

endmodule

### hdl/ray_radial_sector_hit_unit.sv
`timescale 1ns / 1ps
// radial menu hit test for one ray segment per item
// input: pulse start with the six signed q7.16 coordinates; busy is always
//   low, so an item may be given in every cycle
// output: o_done is high for one cycle with within_outer, selected_valid
//   and selected_index; the receiver cannot hold results off
// throughput: one item per cycle
// the pipeline holds the 25-stage divider (a load stage, then one
//   quotient bit a stage) and the 17-stage angle unit (a load stage,
//   then one vectoring step a stage)
// configuration: apb port, child_count at 0x0, menu_visible at 0x4,
//   center_radius at 0x8, outer_radius at 0xc; write only while no item
//   is in flight
// reset: clears the valid bits of the pipeline and restores the registers
//   (no buttons, hidden menu, radii 0.17 and 1.0)
module ray_radial_sector_hit_unit import rsh_pkg::*; #(
    parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_start_x,
    input  logic signed [COORD_W-1:0] i_start_y,
    input  logic signed [COORD_W-1:0] i_start_z,
    input  logic signed [COORD_W-1:0] i_end_x,
    input  logic signed [COORD_W-1:0] i_end_y,
    input  logic signed [COORD_W-1:0] i_end_z,
    output logic                      o_done,
    output logic                      o_within_outer,
    output logic                      o_selected_valid,
    output logic [3:0]                o_selected_index,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    `include "ray_radial_sector_hit_unit_defines.svh"

    localparam logic [4:0] LP_MAX = 5'(MAX_BUTTONS);

    // configuration registers
    logic [3:0]       r_child_count;
    logic             r_menu_visible;
    logic [RAD_W-1:0] r_center_radius;
    logic [RAD_W-1:0] r_outer_radius;
    logic [2*RAD_W-1:0] r_rc_sq;
    logic [2*RAD_W-1:0] r_ro_sq;
    logic             w_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_child_count   <= '0;
            r_menu_visible  <= 1'b0;
            r_center_radius <= CENTER_RADIUS_RST;
            r_outer_radius  <= OUTER_RADIUS_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_CHILD_COUNT:   r_child_count   <= pwdata[3:0];
                REG_MENU_VISIBLE:  r_menu_visible  <= pwdata[0];
                REG_CENTER_RADIUS: r_center_radius <= pwdata[RAD_W-1:0];
                REG_OUTER_RADIUS:  r_outer_radius  <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[3:2])
            REG_CHILD_COUNT:   prdata = {28'd0, r_child_count};
            REG_MENU_VISIBLE:  prdata = {31'd0, r_menu_visible};
            REG_CENTER_RADIUS: prdata = {14'd0, r_center_radius};
            REG_OUTER_RADIUS:  prdata = {14'd0, r_outer_radius};
            default:           prdata = '0;
        endcase
    end

    // squared radii follow the registers
    always_ff @(posedge i_clk) begin
        r_rc_sq <= r_center_radius * r_center_radius;
        r_ro_sq <= r_outer_radius * r_outer_radius;
    end

    // effective button count
    logic [3:0] w_n;
    assign w_n = ({1'b0, r_child_count} > LP_MAX) ? LP_MAX[3:0] : r_child_count;

    // stage 1: cross products and z extent
    logic                     r1_v;
    logic signed [NUM_W-1:0]  r1_pa, r1_pb, r1_pc, r1_pd;
    logic signed [COORD_W:0]  r1_dz;
    logic signed [COORD_W-1:0] r1_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= start;
        r1_pa <= i_start_x * i_end_z;
        r1_pb <= i_start_z * i_end_x;
        r1_pc <= i_start_y * i_end_z;
        r1_pd <= i_start_z * i_end_y;
        r1_dz <= (COORD_W+1)'(i_end_z) - (COORD_W+1)'(i_start_z);
    end
    always_ff @(posedge i_clk) r1_sz <= i_start_z;

    // stage 2: numerators and segment test
    logic                      r2_v, r2_hit;
    logic signed [NUM_W:0]     r2_nx, r2_ny;
    logic signed [COORD_W:0]   r2_dz;
    logic signed [COORD_W+1:0] w_sz, w_dz;
    logic                      w_hit;

    assign w_sz = (COORD_W+2)'(r1_sz);
    assign w_dz = (COORD_W+2)'(r1_dz);
    always_comb begin
        if (r1_dz > 0) begin
            w_hit = (w_sz <= 0) && (-w_sz <= w_dz);
        end else if (r1_dz < 0) begin
            w_hit = (w_sz >= 0) && (w_sz <= -w_dz);
        end else begin
            w_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_hit <= w_hit && r_menu_visible && (w_n != '0);
        r2_nx  <= (NUM_W+1)'(r1_pa) - (NUM_W+1)'(r1_pb);
        r2_ny  <= (NUM_W+1)'(r1_pc) - (NUM_W+1)'(r1_pd);
        r2_dz  <= r1_dz;
    end

    // stage 3: magnitudes and quotient signs
    t_side            r3_sb;
    logic [NUM_W-1:0] r3_mx, r3_my;
    logic [DEN_W-1:0] r3_den;
    logic signed [NUM_W:0]   w_ax, w_ay;
    logic signed [COORD_W:0] w_ad;

    assign w_ax = r2_nx[NUM_W] ? -r2_nx : r2_nx;
    assign w_ay = r2_ny[NUM_W] ? -r2_ny : r2_ny;
    assign w_ad = r2_dz[COORD_W] ? -r2_dz : r2_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_sb.valid <= 1'b0;
        else          r3_sb.valid <= r2_v;
        r3_sb.hit      <= r2_hit;
        r3_sb.neg_x    <= r2_nx[NUM_W] ^ r2_dz[COORD_W];
        r3_sb.neg_y    <= r2_ny[NUM_W] ^ r2_dz[COORD_W];
        r3_sb.in_outer <= 1'b0;
        r3_sb.center   <= 1'b0;
        r3_mx  <= w_ax[NUM_W-1:0];
        r3_my  <= w_ay[NUM_W-1:0];
        r3_den <= w_ad[DEN_W-1:0];
    end

    // hit point coordinates by long division
    logic [QUO_W-1:0] w_qx, w_qy;

    rsh_div u_div_x (
        .i_clk (i_clk),
        .i_num (r3_mx),
        .i_den (r3_den),
        .o_quo (w_qx)
    );

    rsh_div u_div_y (
        .i_clk (i_clk),
        .i_num (r3_my),
        .i_den (r3_den),
        .o_quo (w_qy)
    );

    // control delay beside the divider
    t_side r_dsb [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dsb[0].valid <= 1'b0;
        else          r_dsb[0].valid <= r3_sb.valid;
        r_dsb[0].hit      <= r3_sb.hit;
        r_dsb[0].neg_x    <= r3_sb.neg_x;
        r_dsb[0].neg_y    <= r3_sb.neg_y;
        r_dsb[0].in_outer <= r3_sb.in_outer;
        r_dsb[0].center   <= r3_sb.center;
    end

    for (genvar k = 1; k < DIV_LAT; k++) begin : g_dsb
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dsb[k].valid <= 1'b0;
            else          r_dsb[k].valid <= r_dsb[k-1].valid;
            r_dsb[k].hit      <= r_dsb[k-1].hit;
            r_dsb[k].neg_x    <= r_dsb[k-1].neg_x;
            r_dsb[k].neg_y    <= r_dsb[k-1].neg_y;
            r_dsb[k].in_outer <= r_dsb[k-1].in_outer;
            r_dsb[k].center   <= r_dsb[k-1].center;
        end
    end

    // signed hit point
    t_side                  r_sg_sb;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [XY_W-1:0] w_ux, w_uy;

    assign w_ux = XY_W'({1'b0, w_qx});
    assign w_uy = XY_W'({1'b0, w_qy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sg_sb.valid <= 1'b0;
        else          r_sg_sb.valid <= r_dsb[DIV_LAT-1].valid;
        r_sg_sb.hit      <= r_dsb[DIV_LAT-1].hit;
        r_sg_sb.neg_x    <= r_dsb[DIV_LAT-1].neg_x;
        r_sg_sb.neg_y    <= r_dsb[DIV_LAT-1].neg_y;
        r_sg_sb.in_outer <= 1'b0;
        r_sg_sb.center   <= 1'b0;
        r_x <= r_dsb[DIV_LAT-1].neg_x ? -w_ux : w_ux;
        r_y <= r_dsb[DIV_LAT-1].neg_y ? -w_uy : w_uy;
    end

    // squares
    t_side                    r_sq_sb;
    logic [2*XY_W-1:0]        r_xx, r_yy;
    logic signed [XY_W-1:0]   r_sq_x, r_sq_y;
    logic signed [2*XY_W-1:0] w_xx, w_yy;

    assign w_xx = r_x * r_x;
    assign w_yy = r_y * r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sq_sb.valid <= 1'b0;
        else          r_sq_sb.valid <= r_sg_sb.valid;
        r_sq_sb.hit      <= r_sg_sb.hit;
        r_sq_sb.neg_x    <= r_sg_sb.neg_x;
        r_sq_sb.neg_y    <= r_sg_sb.neg_y;
        r_sq_sb.in_outer <= 1'b0;
        r_sq_sb.center   <= 1'b0;
        r_xx   <= w_xx;
        r_yy   <= w_yy;
        r_sq_x <= r_x;
        r_sq_y <= r_y;
    end

    // radius compares
    t_side                  r_cm_sb;
    logic signed [XY_W-1:0] r_cm_x, r_cm_y;
    logic [2*XY_W:0]        w_d2;

    assign w_d2 = (2*XY_W+1)'(r_xx) + (2*XY_W+1)'(r_yy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cm_sb.valid <= 1'b0;
        else          r_cm_sb.valid <= r_sq_sb.valid;
        r_cm_sb.hit      <= r_sq_sb.hit;
        r_cm_sb.neg_x    <= r_sq_sb.neg_x;
        r_cm_sb.neg_y    <= r_sq_sb.neg_y;
        r_cm_sb.in_outer <= w_d2 <= (2*XY_W+1)'(r_ro_sq);
        r_cm_sb.center   <= w_d2 <  (2*XY_W+1)'(r_rc_sq);
        r_cm_x <= r_sq_x;
        r_cm_y <= r_sq_y;
    end

    // angle of the hit point
    logic [ANG_W-1:0] w_ang;

    rsh_cordic u_cordic (
        .i_clk   (i_clk),
        .i_x     (r_cm_x),
        .i_y     (r_cm_y),
        .o_angle (w_ang)
    );

    // control delay beside the angle unit
    t_side r_csb [0:CORDIC_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_csb[0].valid <= 1'b0;
        else          r_csb[0].valid <= r_cm_sb.valid;
        r_csb[0].hit      <= r_cm_sb.hit;
        r_csb[0].neg_x    <= r_cm_sb.neg_x;
        r_csb[0].neg_y    <= r_cm_sb.neg_y;
        r_csb[0].in_outer <= r_cm_sb.in_outer;
        r_csb[0].center   <= r_cm_sb.center;
    end

    for (genvar k = 1; k < CORDIC_LAT; k++) begin : g_csb
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_csb[k].valid <= 1'b0;
            else          r_csb[k].valid <= r_csb[k-1].valid;
            r_csb[k].hit      <= r_csb[k-1].hit;
            r_csb[k].neg_x    <= r_csb[k-1].neg_x;
            r_csb[k].neg_y    <= r_csb[k-1].neg_y;
            r_csb[k].in_outer <= r_csb[k-1].in_outer;
            r_csb[k].center   <= r_csb[k-1].center;
        end
    end

    // sector from angle and result selection
    t_side            w_fs;
    logic [3:0]       w_m;
    logic [19:0]      w_prod;
    logic [4:0]       w_sec;
    logic [3:0]       n_index;
    logic             n_valid;
    logic             n_within;

    assign w_fs   = r_csb[CORDIC_LAT-1];
    assign w_m    = w_n - 4'd1;
    assign w_prod = 20'(w_ang) * 20'(w_m);
    assign w_sec  = {1'b0, w_prod[19:16]} + 5'd1;

    always_comb begin
        n_within = 1'b0;
        n_valid  = 1'b0;
        n_index  = '0;
        if (w_fs.hit) begin
            n_within = w_fs.in_outer;
            if (w_fs.center) begin
                n_valid = 1'b1;
            end else if (w_fs.in_outer && (w_n > 4'd1)) begin
                n_valid = 1'b1;
                n_index = (w_sec > {1'b0, w_m}) ? w_m : w_sec[3:0];
            end
        end
    end

    // output register
    logic       r_done;
    logic       r_within;
    logic       r_valid;
    logic [3:0] r_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= w_fs.valid;
        r_within <= n_within && w_fs.valid;
        r_valid  <= n_valid && w_fs.valid;
        r_index  <= w_fs.valid ? n_index : '0;
    end

    assign o_done           = r_done;
    assign o_within_outer   = r_within;
    assign o_selected_valid = r_valid;
    assign o_selected_index = r_index;

    // checks
    `RSH_ASSERT_IMP(a_index_needs_sel, i_clk, i_rst_n, o_selected_index != 4'd0, o_selected_valid)
    `RSH_ASSERT_IMP(a_sector_in_outer, i_clk, i_rst_n, o_selected_index != 4'd0, o_within_outer)
    `RSH_ASSERT_IMP(a_flags_need_done, i_clk, i_rst_n, o_within_outer || o_selected_valid, o_done)
    `RSH_ASSERT_NEXT(a_last_stage_done, i_clk, i_rst_n, w_fs.valid, o_done)

endmodule
